@@ src/bbvn_pkg.sv @@
// Shared types and constants for the bounding box vertex normalizer.
// No dependencies; imported by every module of the block except the RAM.
`default_nettype none
package bbvn_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = IDX_W + 1;
    localparam int COORD_W      = 32;
    localparam int FRAC_BITS    = 16;
    localparam int CLIP_W       = FRAC_BITS + 1;
    localparam int NORM_W       = FRAC_BITS + 2;
    localparam int Q_W          = FRAC_BITS + 2;
    localparam int STEP_W       = 5;
    localparam int VTX_W        = 3 * COORD_W;

    localparam logic [CLIP_W-1:0] ONE_FIX = CLIP_W'(1) << FRAC_BITS;
    localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(MAX_VERTICES);
    localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(CLIP_W - 1);
    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(Q_W - 1);

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_ZERO_EXT  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_MUL,
        S_DIV_LOAD,
        S_DIV,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic mul_step;
        logic div_load;
        logic div_step;
    } lane_ctl_t;

endpackage
`default_nettype wire

@@ src/bounding_box_vertex_normalizer.sv @@
// Bounding box vertex normalizer. Add (tuser 0) stores a Q15.16 vertex and widens
// the per-axis box, the first vertex seeding it; read (tuser 1) returns that vertex
// centred on the box and scaled so the largest half-extent maps to clip_bound, in
// Q1.16, with status in m_tuser; clear (tuser 2) empties the model. Input is taken
// only in the idle state. A read of an unloaded index goes from accept straight to
// the output load, and a zero-extent read passes through fetch first. A normal read
// runs through accept, fetch, the 17-step serial multiply, divider load, the 18-step
// serial divide and the output load, with the three lanes running in parallel. A
// stalled output register holds any read in the output load.
// Uses bbvn_pkg, bbvn_ram and bbvn_lane.
`default_nettype none
module bounding_box_vertex_normalizer
    import bbvn_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // coord_x, coord_y, coord_z, vertex_index, zero pad
    input  wire logic [111:0]  s_tdata,
    // cmd
    input  wire logic [1:0]    s_tuser,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // norm_x, norm_y, norm_z, zero pad
    output logic [55:0]        m_tdata,
    // read_status
    output logic [1:0]         m_tuser,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [16:0]   cfg_data
);

    state_t state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CLIP_W-1:0] clip_reg, clip_eff;
    logic signed [COORD_W-1:0] bmin_reg [3];
    logic signed [COORD_W-1:0] bmax_reg [3];
    status_t status_reg;
    logic    m_valid_reg;
    logic [3*NORM_W-1:0] m_data_reg;
    logic [1:0]          m_status_reg;

    logic s_fire, do_add, idx_bad;
    cmd_t cmd;
    logic [IDX_W-1:0] idx;
    logic [VTX_W-1:0] rdata;
    logic [IDX_W-1:0] ram_addr;
    logic signed [COORD_W-1:0] cin [3];
    logic signed [COORD_W-1:0] rd [3];
    logic [COORD_W-1:0] e [3];
    logic [COORD_W-1:0] ext01, ext_max;
    logic signed [NORM_W-1:0] norm [3];
    lane_ctl_t ctl;
    logic out_load;

    assign cmd    = cmd_t'(s_tuser);
    assign idx    = s_tdata[3*COORD_W +: IDX_W];
    assign s_fire = s_tvalid && s_tready;
    assign do_add = s_fire && cmd == CMD_ADD && count_reg != FULL_COUNT;
    assign idx_bad = {1'b0, idx} >= count_reg;
    assign ram_addr = do_add ? count_reg[IDX_W-1:0] : idx;
    assign cfg_ready = 1'b1;
    assign clip_eff = clip_reg > ONE_FIX ? ONE_FIX : clip_reg;

    bbvn_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTICES)) u_store (
        .aclk  (aclk),
        .we    (do_add),
        .addr  (ram_addr),
        .wdata (s_tdata[VTX_W-1:0]),
        .rdata (rdata)
    );

    for (genvar a = 0; a < 3; a++) begin : g_axis
        logic signed [COORD_W:0] span;
        assign cin[a] = s_tdata[a*COORD_W +: COORD_W];
        assign rd[a]  = rdata[a*COORD_W +: COORD_W];
        assign span   = {bmax_reg[a][COORD_W-1], bmax_reg[a]}
                      - {bmin_reg[a][COORD_W-1], bmin_reg[a]};
        assign e[a]   = span[COORD_W-1:0];

        always_ff @(posedge aclk) begin
            if (!aresetn || (s_fire && cmd == CMD_CLEAR)) begin
                bmin_reg[a] <= '0;
                bmax_reg[a] <= '0;
            end else if (do_add) begin
                if (count_reg == '0 || cin[a] < bmin_reg[a]) begin
                    bmin_reg[a] <= cin[a];
                end
                if (count_reg == '0 || cin[a] > bmax_reg[a]) begin
                    bmax_reg[a] <= cin[a];
                end
            end
        end

        bbvn_lane u_lane (
            .aclk  (aclk),
            .ctl   (ctl),
            .coord (rd[a]),
            .bmin  (bmin_reg[a]),
            .bmax  (bmax_reg[a]),
            .clip  (clip_eff),
            .ext   (ext_max),
            .norm  (norm[a])
        );
    end

    assign ext01   = e[0] > e[1] ? e[0] : e[1];
    assign ext_max = ext01 > e[2] ? ext01 : e[2];

    // next state
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_fire && cmd == CMD_READ) begin
                    state_next = idx_bad ? S_DONE : S_FETCH;
                end
            end
            S_FETCH: begin
                step_next  = '0;
                state_next = ext_max == '0 ? S_DONE : S_MUL;
            end
            S_MUL: begin
                step_next = step_reg + 1'b1;
                if (step_reg == MUL_LAST) begin
                    state_next = S_DIV_LOAD;
                end
            end
            S_DIV_LOAD: begin
                step_next  = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                step_next = step_reg + 1'b1;
                if (step_reg == DIV_LAST) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready     = state_reg == S_IDLE;
        ctl.load     = state_reg == S_FETCH && ext_max != '0;
        ctl.mul_step = state_reg == S_MUL;
        ctl.div_load = state_reg == S_DIV_LOAD;
        ctl.div_step = state_reg == S_DIV;
        out_load     = state_reg == S_DONE && (!m_valid_reg || m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            step_reg    <= '0;
            count_reg   <= '0;
            clip_reg    <= ONE_FIX;
            status_reg  <= ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (cfg_valid && cfg_ready) begin
                clip_reg <= cfg_data;
            end
            if (s_fire && cmd == CMD_CLEAR) begin
                count_reg <= '0;
            end else if (do_add) begin
                count_reg <= count_reg + 1'b1;
            end
            if (state_reg == S_IDLE && s_fire && cmd == CMD_READ) begin
                status_reg <= idx_bad ? ST_BAD_INDEX : ST_OK;
            end else if (state_reg == S_FETCH && ext_max == '0) begin
                status_reg <= ST_ZERO_EXT;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg <= status_reg;
            m_data_reg   <= status_reg == ST_OK ? {norm[2], norm[1], norm[0]} : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_data_reg};
    assign m_tuser  = m_status_reg;

endmodule
`default_nettype wire

@@ src/bbvn_ram.sv @@
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none
module bbvn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

@@ src/bbvn_lane.sv @@
// One axis lane: centres a coordinate, then a bit-serial shift-add multiply
// by clip and a restoring divide by the extent with round-to-nearest. Uses bbvn_pkg.
`default_nettype none
module bbvn_lane
    import bbvn_pkg::*;
(
    input  wire logic                      aclk,
    input  wire lane_ctl_t                 ctl,
    input  wire logic signed [COORD_W-1:0] coord,
    input  wire logic signed [COORD_W-1:0] bmin,
    input  wire logic signed [COORD_W-1:0] bmax,
    input  wire logic        [CLIP_W-1:0]  clip,
    input  wire logic        [COORD_W-1:0] ext,
    output logic signed      [NORM_W-1:0]  norm
);

    localparam int PW = COORD_W + 1 + CLIP_W;   // hi accumulator + multiplier bits
    localparam int NW = COORD_W + CLIP_W + 1;   // 2*prod + ext

    logic signed [COORD_W+1:0] d2;
    logic        [COORD_W+1:0] d2_abs;
    logic                      neg_reg;
    logic [COORD_W-1:0]        mag_reg;
    logic [COORD_W-1:0]        ext_reg;
    logic [PW-1:0]             prod_reg;
    logic [COORD_W:0]          rem_reg;
    logic [Q_W-1:0]            low_reg;
    logic [Q_W-1:0]            q_reg;
    logic [COORD_W:0]          sum;
    logic [NW-1:0]             n_val;
    logic [COORD_W+1:0]        trial;
    logic [COORD_W+2:0]        diff;

    // 2v - min - max, always within +-(max - min)
    assign d2 = $signed({coord[COORD_W-1], coord, 1'b0})
              - $signed({{2{bmin[COORD_W-1]}}, bmin})
              - $signed({{2{bmax[COORD_W-1]}}, bmax});
    assign d2_abs = d2[COORD_W+1] ? (~d2 + 1'b1) : d2;

    assign sum = {1'b0, prod_reg[PW-2:CLIP_W]}
               + (prod_reg[0] ? {1'b0, mag_reg} : {(COORD_W+1){1'b0}});

    assign n_val = {prod_reg[PW-2:0], 1'b0} + {{(NW-COORD_W){1'b0}}, ext_reg};

    assign trial = {rem_reg, low_reg[Q_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, ext_reg, 1'b0};

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            neg_reg  <= d2[COORD_W+1];
            mag_reg  <= d2_abs[COORD_W-1:0];
            ext_reg  <= ext;
            prod_reg <= {{(PW-CLIP_W){1'b0}}, clip};
        end else if (ctl.mul_step) begin
            prod_reg <= {1'b0, sum, prod_reg[CLIP_W-1:1]};
        end
        if (ctl.div_load) begin
            rem_reg <= {1'b0, n_val[NW-1:Q_W]};
            low_reg <= n_val[Q_W-1:0];
            q_reg   <= '0;
        end else if (ctl.div_step) begin
            rem_reg <= diff[COORD_W+2] ? trial[COORD_W:0] : diff[COORD_W:0];
            low_reg <= {low_reg[Q_W-2:0], 1'b0};
            q_reg   <= {q_reg[Q_W-2:0], ~diff[COORD_W+2]};
        end
    end

    assign norm = neg_reg ? $signed(~q_reg + 1'b1) : $signed(q_reg);

endmodule
`default_nettype wire

@@ test/testbench.sv @@
// Testbench for bounding_box_vertex_normalizer: directed and random add/read/clear
// traffic, checked against an in-bench box normalizer held in a scoreboard class.
// Depends on bbvn_pkg and the block's RTL.
`timescale 1ns / 1ps
import bbvn_pkg::*;

typedef struct {
    logic [17:0] nx;
    logic [17:0] ny;
    logic [17:0] nz;
    status_t     st;
} norm_result_t;

class box_scoreboard;
    logic signed [31:0] verts [MAX_VERTICES][3];
    int unsigned        n_verts;
    logic signed [31:0] lo [3];
    logic signed [31:0] hi [3];
    logic [16:0]        clip;
    norm_result_t       pending [$];
    int                 errors;

    function new();
        n_verts = 0;
        clip = 17'd65536;
        errors = 0;
        for (int a = 0; a < 3; a++) begin
            lo[a] = 0;
            hi[a] = 0;
        end
    endfunction

    function logic [17:0] scale(longint v, longint mn, longint mx, longint c, longint e);
        longint d2;
        longint mag;
        longint q;
        d2 = 2 * v - (mn + mx);
        mag = d2 < 0 ? -d2 : d2;
        q = (2 * c * mag + e) / (2 * e);
        if (d2 < 0) q = -q;
        return q[17:0];
    endfunction

    // called for each accepted input transaction
    function void note_input(cmd_t cmd, logic signed [31:0] c [3], logic [9:0] idx);
        norm_result_t r;
        longint ext;
        longint cl;
        case (cmd)
            CMD_ADD: begin
                if (n_verts < MAX_VERTICES) begin
                    for (int a = 0; a < 3; a++) begin
                        verts[n_verts][a] = c[a];
                        if (n_verts == 0 || c[a] < lo[a]) lo[a] = c[a];
                        if (n_verts == 0 || c[a] > hi[a]) hi[a] = c[a];
                    end
                    n_verts++;
                end
            end
            CMD_READ: begin
                r.nx = 0; r.ny = 0; r.nz = 0; r.st = ST_OK;
                cl = clip > ONE_FIX ? ONE_FIX : clip;
                ext = 0;
                for (int a = 0; a < 3; a++)
                    if (longint'(hi[a]) - longint'(lo[a]) > ext)
                        ext = longint'(hi[a]) - longint'(lo[a]);
                if (idx >= n_verts) r.st = ST_BAD_INDEX;
                else if (ext == 0) r.st = ST_ZERO_EXT;
                else begin
                    r.nx = scale(verts[idx][0], lo[0], hi[0], cl, ext);
                    r.ny = scale(verts[idx][1], lo[1], hi[1], cl, ext);
                    r.nz = scale(verts[idx][2], lo[2], hi[2], cl, ext);
                end
                pending.insert(pending.size(), r);
            end
            CMD_CLEAR: begin
                n_verts = 0;
                for (int a = 0; a < 3; a++) begin
                    lo[a] = 0;
                    hi[a] = 0;
                end
            end
            default: ;
        endcase
    endfunction

    task report(string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    task check_result(logic [55:0] data, logic [1:0] user);
        norm_result_t e;
        if (pending.size() == 0) begin
            report($sformatf("unexpected result %h/%0d", data, user));
            return;
        end
        e = pending.pop_front();
        if (data[17:0] !== e.nx) report($sformatf("norm_x %h exp %h", data[17:0], e.nx));
        if (data[35:18] !== e.ny) report($sformatf("norm_y %h exp %h", data[35:18], e.ny));
        if (data[53:36] !== e.nz) report($sformatf("norm_z %h exp %h", data[53:36], e.nz));
        if (data[55:54] !== 2'b0) report("tdata pad not zero");
        if (user !== e.st) report($sformatf("status %0d exp %0d", user, e.st));
    endtask
endclass

module testbench;
    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [111:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [55:0]  m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [16:0]  cfg_data;

    box_scoreboard sb;
    int            cycles = 0;
    int            stall_mode;
    localparam int CYCLE_LIMIT = 400000;

    bounding_box_vertex_normalizer dut (.*);

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    // watchdog and input/output monitor
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
        if (aresetn && s_tvalid && s_tready) begin
            logic signed [31:0] c [3];
            c[0] = s_tdata[31:0];
            c[1] = s_tdata[63:32];
            c[2] = s_tdata[95:64];
            sb.note_input(cmd_t'(s_tuser), c, s_tdata[105:96]);
        end
    end

    // receiver stall pattern; mode changes from phase to phase
    always @(posedge aclk) begin
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (cycles % 7) < 3;
        endcase
    end

    task automatic send(cmd_t cmd, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                        logic [9:0] idx);
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {6'b0, idx, z, y, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic pause_gap();
        int g;
        g = $urandom_range(0, 5) == 0 ? $urandom_range(1, 12) : 0;
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic write_clip(logic [16:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.clip = v;
        @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 8;
            2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 40)) - 20);
        endcase
    endfunction

    task automatic random_phase(int n_items);
        int cm;
        int mode;
        logic [9:0] idx;
        mode = $urandom_range(0, 3);
        send(CMD_CLEAR, 0, 0, 0, 0);
        for (int i = 0; i < n_items; i++) begin
            cm = $urandom_range(0, 19);
            if (cm < 8) begin
                if ($urandom_range(0, 7) == 0) mode = $urandom_range(0, 3);
                send(CMD_ADD, rand_coord(mode), rand_coord(mode), rand_coord(mode),
                     10'($urandom()));
            end else if (cm < 18) begin
                idx = (sb.n_verts > 0 && $urandom_range(0, 7) != 0) ?
                      10'($urandom_range(0, sb.n_verts - 1)) : 10'($urandom());
                send(CMD_READ, $urandom(), $urandom(), $urandom(), idx);
            end else if (cm == 18) begin
                send($urandom_range(0, 3) == 0 ? CMD_CLEAR : CMD_NONE,
                     $urandom(), $urandom(), $urandom(), 10'($urandom()));
            end else begin
                pause_gap();
            end
            pause_gap();
        end
        drain();
    endtask

    initial begin
        sb = new();
        stall_mode = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_NONE;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty reads, zero extent, extremes, unused command
        send(CMD_READ, 0, 0, 0, 10'd0);
        send(CMD_READ, 0, 0, 0, 10'd1023);
        send(CMD_ADD, 32'h00010000, 32'hffff0000, 0, 0);
        send(CMD_READ, 0, 0, 0, 10'd0);
        send(CMD_ADD, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0);
        send(CMD_ADD, 32'h80000000, 32'h7fffffff, 32'h80000000, 0);
        send(CMD_READ, 0, 0, 0, 10'd0);
        send(CMD_READ, 0, 0, 0, 10'd1);
        send(CMD_READ, 0, 0, 0, 10'd2);
        send(CMD_READ, 0, 0, 0, 10'd3);
        send(CMD_NONE, 32'hffffffff, 32'hffffffff, 32'hffffffff, 10'h3ff);
        send(CMD_ADD, 32'h3, 32'h5, 32'h7, 0);
        send(CMD_READ, 0, 0, 0, 10'd3);
        send(CMD_CLEAR, 0, 0, 0, 0);
        send(CMD_READ, 0, 0, 0, 10'd0);
        send(CMD_ADD, 32'd1, 32'd2, 32'd3, 0);
        send(CMD_ADD, 32'd2, 32'd2, 32'd3, 0);
        send(CMD_READ, 0, 0, 0, 10'd0);
        send(CMD_READ, 0, 0, 0, 10'd1);
        drain();

        // fill the store to the limit, then add past it
        write_clip(17'd0);
        send(CMD_CLEAR, 0, 0, 0, 0);
        for (int i = 0; i < MAX_VERTICES + 4; i++)
            send(CMD_ADD, $urandom(), $urandom(), $urandom(), 0);
        send(CMD_READ, 0, 0, 0, 10'd1023);
        send(CMD_READ, 0, 0, 0, 10'd0);
        drain();

        for (int p = 0; p < 6; p++) begin
            stall_mode = p % 4;
            case (p)
                0: write_clip(17'd65536);
                1: write_clip(17'h1ffff);
                2: write_clip(17'd1);
                default: write_clip(17'($urandom()));
            endcase
            random_phase(15);
        end
        stall_mode = 0;
        write_clip(17'd65536);
        random_phase(10);

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

@@ bounding_box_vertex_normalizer.f @@
src/bbvn_pkg.sv
src/bbvn_ram.sv
src/bbvn_lane.sv
src/bounding_box_vertex_normalizer.sv
test/testbench.sv
